/* rtl/dbs_pkg.sv */
// dbs_pkg: shared types and constants for the depth bucket sorter
// used by every module of the block, depends on nothing
`timescale 1ns / 1ps
package dbs_pkg;
  localparam int unsigned DEPTH_W = 12;
  localparam int unsigned KEY_W   = 14;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned IN_W    = 40;
  localparam int unsigned OUT_W   = 16;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef struct packed {
    logic               op;
    logic [KEY_W-1:0]   key;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              valid_res;
    logic [SLOT_W-1:0] slot;
    logic              final_item;
  } res_t;
endpackage

/* rtl/depth_bucket_sorter.sv */
// depth_bucket_sorter: painter's order sorter, an add walks its bucket's list from both ends
// a take scans down past empty buckets to the next item; one request at a time in the back
// after the last take and after reset, a clearing pass over all buckets resets bucket heads
// synchronous active-low reset clears control state; a 2-entry queue decouples front and back
// depends on dbs_pkg, dbs_front, dbs_back
`timescale 1ns / 1ps
module depth_bucket_sorter #(
  parameter int unsigned ENTRIES   = 256,
  parameter int unsigned BUCKETS   = 512,
  parameter int unsigned KEY_SHIFT = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // depth_a, depth_b, depth_c, zero pad
  input  logic        in_tuser,  // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // accepted, valid_res, slot, final_item, zero pad
);
  logic          cmd_valid, cmd_ready;
  dbs_pkg::cmd_t cmd;
  dbs_pkg::res_t res;

  dbs_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .op(in_tuser),
    .da(in_tdata[11:0]), .db(in_tdata[23:12]), .dc(in_tdata[35:24]),
    .cmd_valid, .cmd_ready, .cmd
  );

  dbs_back #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS), .KEY_SHIFT(KEY_SHIFT)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {5'b0, res.final_item, res.slot, res.valid_res, res.accepted};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("add and take flags both set");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[1])
    else $error("final without slot");
endmodule

/* rtl/dbs_front.sv */
// dbs_front: accepts input requests, forms the key and queues commands
// depends on dbs_pkg
`timescale 1ns / 1ps
module dbs_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic [dbs_pkg::DEPTH_W-1:0] da,
  input  logic [dbs_pkg::DEPTH_W-1:0] db,
  input  logic [dbs_pkg::DEPTH_W-1:0] dc,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output dbs_pkg::cmd_t            cmd
);
  dbs_pkg::cmd_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  dbs_pkg::cmd_t c_in;
  logic          push, pop;

  assign c_in.op  = op;
  assign c_in.key = dbs_pkg::KEY_W'({2'b0, da}) + dbs_pkg::KEY_W'({2'b0, db})
                  + dbs_pkg::KEY_W'({2'b0, dc});
  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c_in;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/dbs_back.sv */
// dbs_back: bucket list store, insertion walk and draining sequencer
// depends on dbs_pkg
`timescale 1ns / 1ps
module dbs_back #(
  parameter int unsigned ENTRIES   = 256,
  parameter int unsigned BUCKETS   = 512,
  parameter int unsigned KEY_SHIFT = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  dbs_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output dbs_pkg::res_t res
);
  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned LW = EW + 1;
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned CW = BW + 1;
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam logic [BW-1:0] BTOP = BW'(BUCKETS - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_BRD, S_BWAIT, S_HK, S_HKW, S_CMP, S_NXT, S_NXTW,
    S_LNK, S_LNK2, S_TSCAN, S_TSW, S_TNODE, S_TNW, S_OUT
  } st_t;

  logic [dbs_pkg::KEY_W-1:0] key_mem [ENTRIES];
  logic [LW-1:0] nxt_mem [ENTRIES];
  logic [LW-1:0] prv_mem [ENTRIES];
  logic [LW-1:0] hd_mem  [BUCKETS];
  logic [LW-1:0] tl_mem  [BUCKETS];

  st_t st_r;
  logic [CW-1:0] clr_r;
  logic [LW-1:0] cnt_r, tkn_r, dnode_r, h_r, t_r, n_r, hq_r, tq_r;
  logic [BW-1:0] dbkt_r, b_r;
  logic [dbs_pkg::KEY_W-1:0] key_r, kh_r, kt_r;
  logic [LW-1:0] rnh_r, rph_r, rnt_r, rpt_r, hd_q_r, tl_q_r;
  logic [LW-1:0] guard_r;
  logic [1:0] mode_r;
  logic res_valid_r;
  dbs_pkg::res_t res_r;
  logic [dbs_pkg::KEY_W-1:0] bsh;

  assign res_valid = res_valid_r;
  assign res = res_r;
  assign cmd_ready = (st_r == S_IDLE) && !res_valid_r;
  assign bsh = cmd.key >> KEY_SHIFT;

  always_ff @(posedge clk) begin
    hd_q_r <= hd_mem[b_r];
    tl_q_r <= tl_mem[b_r];
    kh_r   <= key_mem[h_r[EW-1:0]];
    kt_r   <= key_mem[t_r[EW-1:0]];
    rnh_r  <= nxt_mem[h_r[EW-1:0]];
    rph_r  <= prv_mem[h_r[EW-1:0]];
    rnt_r  <= nxt_mem[t_r[EW-1:0]];
    rpt_r  <= prv_mem[t_r[EW-1:0]];
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; res_valid_r <= 1'b0;
      cnt_r <= '0; tkn_r <= '0; dbkt_r <= BTOP; dnode_r <= NIL;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          hd_mem[clr_r[BW-1:0]] <= NIL;
          tl_mem[clr_r[BW-1:0]] <= NIL;
          clr_r <= clr_r + 1'b1;
          if (clr_r == CW'(BUCKETS - 1)) begin
            st_r <= S_IDLE; cnt_r <= '0; tkn_r <= '0;
            dbkt_r <= BTOP; dnode_r <= NIL;
          end
        end
        S_IDLE: if (cmd_valid && !res_valid_r) begin
          res_r <= '0;
          if (cmd.op == dbs_pkg::OP_ADD) begin
            if (cnt_r == NIL || tkn_r != '0) begin
              res_valid_r <= 1'b1;
            end else begin
              key_r <= cmd.key;
              n_r   <= cnt_r;
              key_mem[cnt_r[EW-1:0]] <= cmd.key;
              b_r <= (bsh > dbs_pkg::KEY_W'(BUCKETS - 1)) ? BTOP : bsh[BW-1:0];
              guard_r <= '0;
              st_r <= S_BRD;
            end
          end else if (tkn_r >= cnt_r) begin
            res_valid_r <= 1'b1;
          end else if (dnode_r == NIL) begin
            b_r <= dbkt_r; st_r <= S_TSW;
          end else begin
            h_r <= dnode_r; st_r <= S_TNW;
          end
        end
        S_BRD: st_r <= S_BWAIT;
        S_BWAIT: begin h_r <= hd_q_r; t_r <= tl_q_r; st_r <= S_HK; end
        S_HK: begin
          if (h_r == NIL || t_r == NIL || guard_r == NIL) begin
            mode_r <= 2'd2; st_r <= S_LNK;
          end else st_r <= S_HKW;
        end
        S_HKW: st_r <= S_CMP;
        S_CMP: begin
          if (kh_r <= key_r) begin
            mode_r <= 2'd0; hq_r <= rph_r; st_r <= S_LNK;
          end else if (kt_r >= key_r) begin
            mode_r <= 2'd1; tq_r <= rnt_r; st_r <= S_LNK;
          end else begin
            h_r <= rnh_r; t_r <= rpt_r; guard_r <= guard_r + 1'b1; st_r <= S_HK;
          end
        end
        S_LNK: begin
          unique case (mode_r)
            2'd0: begin
              prv_mem[n_r[EW-1:0]] <= hq_r;
              nxt_mem[n_r[EW-1:0]] <= h_r;
              if (hq_r == NIL) hd_mem[b_r] <= n_r; else nxt_mem[hq_r[EW-1:0]] <= n_r;
            end
            2'd1: begin
              nxt_mem[n_r[EW-1:0]] <= tq_r;
              prv_mem[n_r[EW-1:0]] <= t_r;
              if (tq_r == NIL) tl_mem[b_r] <= n_r; else prv_mem[tq_r[EW-1:0]] <= n_r;
            end
            default: begin
              prv_mem[n_r[EW-1:0]] <= tl_q_r;
              nxt_mem[n_r[EW-1:0]] <= NIL;
              if (tl_q_r == NIL) hd_mem[b_r] <= n_r;
              else nxt_mem[tl_q_r[EW-1:0]] <= n_r;
              tl_mem[b_r] <= n_r;
            end
          endcase
          st_r <= S_LNK2;
        end
        S_LNK2: begin
          if (mode_r == 2'd0) prv_mem[h_r[EW-1:0]] <= n_r;
          else if (mode_r == 2'd1) nxt_mem[t_r[EW-1:0]] <= n_r;
          cnt_r <= cnt_r + 1'b1;
          res_r.accepted <= 1'b1;
          res_r.slot <= dbs_pkg::SLOT_W'(n_r);
          res_valid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_TSW: st_r <= S_TSCAN;
        S_TSCAN: begin
          if (hd_q_r != NIL) begin
            dbkt_r <= b_r; h_r <= hd_q_r; st_r <= S_TNW;
          end else if (b_r == '0) begin
            res_valid_r <= 1'b1; st_r <= S_IDLE;
          end else begin
            b_r <= b_r - 1'b1; st_r <= S_TSW;
          end
        end
        S_TNW: st_r <= S_TNODE;
        S_TNODE: begin
          res_r.valid_res <= 1'b1;
          res_r.slot <= dbs_pkg::SLOT_W'(h_r);
          if (rnh_r >= NIL) begin
            dnode_r <= NIL;
            if (dbkt_r != '0) dbkt_r <= dbkt_r - 1'b1;
          end else dnode_r <= rnh_r;
          tkn_r <= tkn_r + 1'b1;
          if (tkn_r + 1'b1 >= cnt_r) begin
            res_r.final_item <= 1'b1;
            clr_r <= '0;
            st_r <= S_OUT;
          end else begin
            res_valid_r <= 1'b1; st_r <= S_IDLE;
          end
        end
        S_OUT: begin res_valid_r <= 1'b1; st_r <= S_CLR; end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
